[design/mbp_pkg.sv]
// Shared types, constants and command encodings for the 2-2-1 backprop trainer.
// Used by the sigmoid table, the controller, the datapath and the top level.
package mbp_pkg;

  localparam int FRAC      = 16;               // fraction bits of every fixed-point value
  localparam int SIG_DEPTH = 1024;             // sigmoid table entries over [-8, 8)
  localparam int SIG_AW    = $clog2(SIG_DEPTH);
  localparam int WW        = 24;               // stored weight width
  localparam int XW        = 26;               // working width of sums and operands
  localparam int PW        = 2 * XW;           // full product width
  localparam int YW        = FRAC + 1;         // activation width, 0..1 inclusive
  localparam int EW        = 20;               // epoch sum width
  localparam int LRW       = 18;
  localparam int NUM_W     = 9;
  localparam int WIW       = 4;
  localparam int CFG_AW    = 3;

  localparam logic [EW-1:0]  EPOCH_MAX = {EW{1'b1}};
  localparam logic [LRW-1:0] LR_RESET  = 18'd41812;
  localparam logic [EW-1:0]  THR_RESET = 20'd66;

  // stored weights by index
  localparam logic [WIW-1:0] WI_X1H1 = 4'd0;
  localparam logic [WIW-1:0] WI_X2H1 = 4'd1;
  localparam logic [WIW-1:0] WI_X1H2 = 4'd2;
  localparam logic [WIW-1:0] WI_X2H2 = 4'd3;
  localparam logic [WIW-1:0] WI_H1O  = 4'd4;
  localparam logic [WIW-1:0] WI_H2O  = 4'd5;
  localparam logic [WIW-1:0] WI_BH1  = 4'd6;
  localparam logic [WIW-1:0] WI_BH2  = 4'd7;
  localparam logic [WIW-1:0] WI_BO   = 4'd8;

  localparam logic signed [WW-1:0] W_RESET [NUM_W] = '{
    24'sd32768, 24'sd26214, 24'sd58982, 24'sd65536,
    -24'sd78643, 24'sd72090, 24'sd52429, -24'sd6554, 24'sd19661
  };

  localparam logic CMD_TRAIN = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  localparam logic REG_LR  = 1'b0;
  localparam logic REG_THR = 1'b1;

  localparam logic [4:0] FWD_LAST  = 5'd8;
  localparam logic [4:0] BACK_LAST = 5'd16;
  localparam logic [4:0] ERR_LAST  = 5'd2;

  typedef enum logic [2:0] {ST_IDLE, ST_READ, ST_FWD, ST_BACK, ST_ERR} state_t;

  typedef enum logic [2:0] {ACC_HOLD, ACC_H1, ACC_H2, ACC_B2M, ACC_ADDM} acc_op_t;

  typedef enum logic [1:0] {SIG_NONE, SIG_Y1, SIG_Y2, SIG_YO} sig_wb_t;

  typedef enum logic [4:0] {
    SRC_Y1, SRC_Y2, SRC_YO, SRC_OMY1, SRC_OMY2, SRC_OMYO, SRC_ERR, SRC_M, SRC_LR,
    SRC_T1, SRC_T2, SRC_LA, SRC_LB, SRC_DOUT, SRC_D1, SRC_D2, SRC_WO1, SRC_WO2
  } src_t;

  typedef enum logic [2:0] {TMP_NONE, TMP_T1, TMP_T2, TMP_LA, TMP_LB, TMP_DOUT, TMP_D1, TMP_D2}
    tmp_t;

  typedef enum logic [2:0] {UPD_NONE, UPD_WO1, UPD_WO2, UPD_B2, UPD_H1, UPD_H2} upd_t;

  typedef struct packed {
    logic    load;
    acc_op_t acc_op;
    sig_wb_t sig_wb;
    logic    mul_en;
    src_t    mul_a;
    src_t    mul_b;
    tmp_t    m_wb;
    upd_t    upd;
    logic    save_pred;
    logic    out_train;
    logic    out_read;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } stat_t;

endpackage

[design/mbp_sig_rom.sv]
// Sigmoid lookup table over [-8, 8), entries built at elaboration, registered read.
// Depends on mbp_pkg for depth and fraction width.
module mbp_sig_rom (
  input  logic                       clk,
  input  logic [mbp_pkg::SIG_AW-1:0] addr,
  output logic [mbp_pkg::YW-1:0]     q
);
  import mbp_pkg::*;

  localparam logic [63:0] Q30 = 64'd1 << 30;
  localparam logic [63:0] E1  = 64'd395007542;   // e^-1 in Q30

  logic [YW-1:0] tbl [SIG_DEPTH];
  logic [YW-1:0] q_r;

  for (genvar i = 0; i < SIG_DEPTH; i++) begin : g_ent
    localparam logic [63:0] OFF = (64'(2 * i + 1) << 33) / SIG_DEPTH;
    localparam bit          NEG = OFF < (64'd1 << 33);
    localparam logic [63:0] MAG = NEG ? (64'd1 << 33) - OFF : OFF - (64'd1 << 33);
    localparam logic [63:0] NI  = MAG >> 30;
    localparam logic [63:0] G   = Q30 - (MAG & (Q30 - 64'd1));
    // Taylor series of e^(1-f), each term truncated
    localparam logic [63:0] T1  = ((Q30 * G) >> 30) / 1;
    localparam logic [63:0] T2  = ((T1 * G) >> 30) / 2;
    localparam logic [63:0] T3  = ((T2 * G) >> 30) / 3;
    localparam logic [63:0] T4  = ((T3 * G) >> 30) / 4;
    localparam logic [63:0] T5  = ((T4 * G) >> 30) / 5;
    localparam logic [63:0] T6  = ((T5 * G) >> 30) / 6;
    localparam logic [63:0] T7  = ((T6 * G) >> 30) / 7;
    localparam logic [63:0] T8  = ((T7 * G) >> 30) / 8;
    localparam logic [63:0] T9  = ((T8 * G) >> 30) / 9;
    localparam logic [63:0] T10 = ((T9 * G) >> 30) / 10;
    localparam logic [63:0] T11 = ((T10 * G) >> 30) / 11;
    localparam logic [63:0] T12 = ((T11 * G) >> 30) / 12;
    localparam logic [63:0] T13 = ((T12 * G) >> 30) / 13;
    localparam logic [63:0] T14 = ((T13 * G) >> 30) / 14;
    localparam logic [63:0] SUM = Q30 + T1 + T2 + T3 + T4 + T5 + T6 + T7 + T8 + T9 + T10
                                  + T11 + T12 + T13 + T14;
    // multiply by e^-1 once for the whole part plus one
    localparam logic [63:0] P0  = (SUM * E1) >> 30;
    localparam logic [63:0] P1  = (NI >= 1) ? (P0 * E1) >> 30 : P0;
    localparam logic [63:0] P2  = (NI >= 2) ? (P1 * E1) >> 30 : P1;
    localparam logic [63:0] P3  = (NI >= 3) ? (P2 * E1) >> 30 : P2;
    localparam logic [63:0] P4  = (NI >= 4) ? (P3 * E1) >> 30 : P3;
    localparam logic [63:0] P5  = (NI >= 5) ? (P4 * E1) >> 30 : P4;
    localparam logic [63:0] P6  = (NI >= 6) ? (P5 * E1) >> 30 : P5;
    localparam logic [63:0] P7  = (NI >= 7) ? (P6 * E1) >> 30 : P6;
    localparam logic [63:0] DEN = Q30 + P7;
    localparam logic [63:0] S   = ((64'd1 << (FRAC + 30)) + DEN / 2) / DEN;
    localparam logic [63:0] V   = NEG ? (64'd1 << FRAC) - S : S;
    assign tbl[i] = V[YW-1:0];
  end

  always_ff @(posedge clk) begin
    q_r <= tbl[addr];
  end

  assign q = q_r;

endmodule

[design/mbp_ctrl.sv]
// Sequencer for the trainer: forward pass, backprop schedule, second pass, error.
// Depends on mbp_pkg for state, command and status types.
module mbp_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  input  logic           in_tuser,
  input  mbp_pkg::stat_t stat,
  output logic           in_tready,
  output mbp_pkg::cmd_t  cmd
);
  import mbp_pkg::*;

  state_t     state_r, state_nxt;
  logic [4:0] step_r, step_nxt;
  logic       pass_r, pass_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
      pass_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      pass_r  <= pass_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r + 5'd1;
    pass_nxt  = pass_r;
    case (state_r)
      ST_IDLE: begin
        step_nxt = '0;
        pass_nxt = 1'b0;
        if (in_tvalid) begin
          state_nxt = (in_tuser == CMD_READ) ? ST_READ : ST_FWD;
        end
      end
      ST_READ: begin
        step_nxt = '0;
        if (stat.out_free) state_nxt = ST_IDLE;
      end
      ST_FWD: begin
        if (step_r == FWD_LAST) begin
          step_nxt  = '0;
          state_nxt = pass_r ? ST_ERR : ST_BACK;
        end
      end
      ST_BACK: begin
        if (step_r == BACK_LAST) begin
          step_nxt  = '0;
          pass_nxt  = 1'b1;
          state_nxt = ST_FWD;
        end
      end
      ST_ERR: begin
        if (step_r == ERR_LAST) begin
          step_nxt = step_r;
          if (stat.out_free) begin
            step_nxt  = '0;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        step_nxt  = '0;
      end
    endcase
  end

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    cmd           = '0;
    cmd.acc_op    = ACC_HOLD;
    cmd.sig_wb    = SIG_NONE;
    cmd.mul_a     = SRC_M;
    cmd.mul_b     = SRC_M;
    cmd.m_wb      = TMP_NONE;
    cmd.upd       = UPD_NONE;
    cmd.load      = (state_r == ST_IDLE) && in_tvalid;
    case (state_r)
      ST_READ: cmd.out_read = stat.out_free;
      ST_FWD: begin
        case (step_r)
          5'd0: cmd.acc_op = ACC_H1;
          5'd1: cmd.acc_op = ACC_H2;
          5'd2: cmd.sig_wb = SIG_Y1;
          5'd3: begin
            cmd.sig_wb = SIG_Y2;
            cmd.mul_en = 1'b1; cmd.mul_a = SRC_Y1; cmd.mul_b = SRC_WO1;
          end
          5'd4: begin cmd.mul_en = 1'b1; cmd.mul_a = SRC_Y2; cmd.mul_b = SRC_WO2; end
          5'd5: cmd.acc_op = ACC_B2M;
          5'd6: cmd.acc_op = ACC_ADDM;
          5'd8: cmd.sig_wb = SIG_YO;
          default: ;
        endcase
      end
      ST_BACK: begin
        case (step_r)
          5'd0: begin
            cmd.save_pred = 1'b1;
            cmd.mul_en = 1'b1; cmd.mul_a = SRC_YO; cmd.mul_b = SRC_OMYO;
          end
          5'd1: begin cmd.mul_en = 1'b1; cmd.mul_a = SRC_Y1; cmd.mul_b = SRC_OMY1; end
          5'd2: begin cmd.mul_en = 1'b1; cmd.mul_a = SRC_M; cmd.mul_b = SRC_ERR; end
          5'd3: begin
            cmd.mul_en = 1'b1; cmd.mul_a = SRC_Y2; cmd.mul_b = SRC_OMY2; cmd.m_wb = TMP_T1;
          end
          5'd4: begin
            cmd.mul_en = 1'b1; cmd.mul_a = SRC_LR; cmd.mul_b = SRC_Y1; cmd.m_wb = TMP_DOUT;
          end
          5'd5: begin
            cmd.mul_en = 1'b1; cmd.mul_a = SRC_T1; cmd.mul_b = SRC_DOUT; cmd.m_wb = TMP_T2;
          end
          5'd6: begin
            cmd.mul_en = 1'b1; cmd.mul_a = SRC_LR; cmd.mul_b = SRC_Y2; cmd.m_wb = TMP_LA;
          end
          5'd7: begin
            cmd.mul_en = 1'b1; cmd.mul_a = SRC_T2; cmd.mul_b = SRC_DOUT; cmd.m_wb = TMP_T1;
          end
          5'd8: begin
            cmd.mul_en = 1'b1; cmd.mul_a = SRC_LA; cmd.mul_b = SRC_DOUT; cmd.m_wb = TMP_LB;
          end
          5'd9: begin
            cmd.mul_en = 1'b1; cmd.mul_a = SRC_T1; cmd.mul_b = SRC_WO1; cmd.m_wb = TMP_T2;
          end
          5'd10: begin
            cmd.mul_en = 1'b1; cmd.mul_a = SRC_LB; cmd.mul_b = SRC_DOUT; cmd.upd = UPD_WO1;
          end
          5'd11: begin
            cmd.mul_en = 1'b1; cmd.mul_a = SRC_T2; cmd.mul_b = SRC_WO2; cmd.m_wb = TMP_D1;
          end
          5'd12: begin
            cmd.mul_en = 1'b1; cmd.mul_a = SRC_LR; cmd.mul_b = SRC_DOUT; cmd.upd = UPD_WO2;
          end
          5'd13: begin
            cmd.mul_en = 1'b1; cmd.mul_a = SRC_LR; cmd.mul_b = SRC_D1; cmd.m_wb = TMP_D2;
          end
          5'd14: begin
            cmd.mul_en = 1'b1; cmd.mul_a = SRC_LR; cmd.mul_b = SRC_D2; cmd.upd = UPD_B2;
          end
          5'd15: cmd.upd = UPD_H1;
          5'd16: cmd.upd = UPD_H2;
          default: ;
        endcase
      end
      ST_ERR: begin
        case (step_r)
          5'd0: begin cmd.mul_en = 1'b1; cmd.mul_a = SRC_ERR; cmd.mul_b = SRC_ERR; end
          5'd2: cmd.out_train = stat.out_free;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

endmodule

[design/mbp_datapath.sv]
// Datapath: weight registers, shared rounding multiplier, sums, sigmoid, result slot.
// Depends on mbp_pkg and mbp_sig_rom; driven by commands from mbp_ctrl.
module mbp_datapath (
  input  logic                    clk,
  input  logic                    rst_n,
  input  mbp_pkg::cmd_t           cmd,
  output mbp_pkg::stat_t          stat,
  input  logic [7:0]              in_tdata,
  input  logic                    in_tlast,
  input  logic [mbp_pkg::LRW-1:0] learning_rate,
  input  logic [mbp_pkg::EW-1:0]  error_threshold,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [79:0]             out_tdata
);
  import mbp_pkg::*;

  localparam logic signed [XW-1:0] ONE  = XW'(1 << FRAC);
  localparam logic signed [XW-1:0] EIGHT = XW'(8 << FRAC);
  localparam logic signed [PW-1:0] HALF = PW'(1 << (FRAC - 1));
  localparam int                   SW   = FRAC + 4 + SIG_AW + 1;
  localparam logic signed [WW-1:0] W_MAXV = {1'b0, {(WW-1){1'b1}}};
  localparam logic signed [WW-1:0] W_MINV = {1'b1, {(WW-1){1'b0}}};

  logic signed [WW-1:0] w_r [NUM_W];
  logic                 a_r, b_r, tgt_r, last_r;
  logic [WIW-1:0]       idx_r;
  logic signed [XW-1:0] acc_r, acc_nxt;
  logic [YW-1:0]        y1_r, y2_r, yo_r, pred_r;
  logic signed [XW-1:0] t1_r, t2_r, la_r, lb_r, dout_r, d1_r, d2_r;
  logic signed [PW-1:0] p_r, p_rnd;
  logic signed [XW-1:0] m_r, opa, opb, err;
  logic [EW-1:0]        epoch_r;
  logic                 out_valid_r;
  logic [79:0]          out_data_r;
  logic [SIG_AW-1:0]    sig_addr;
  logic [YW-1:0]        sig_q;
  logic [FRAC+3:0]      off;
  logic [SW-1:0]        scaled;
  logic [YW-1:0]        e2;
  logic [EW:0]          sum_w;
  logic [EW-1:0]        sum_sat;
  logic signed [WW-1:0] rd_w;

  function automatic logic signed [WW-1:0] sat_add(logic signed [WW-1:0] w,
                                                   logic signed [XW-1:0] d);
    logic signed [XW:0] s;
    s = (XW+1)'(w) + (XW+1)'(d);
    if (s > (XW+1)'(W_MAXV)) return W_MAXV;
    if (s < (XW+1)'(W_MINV)) return W_MINV;
    return s[WW-1:0];
  endfunction

  assign err = (tgt_r ? ONE : '0) - XW'(yo_r);

  function automatic logic signed [XW-1:0] pick(src_t s);
    case (s)
      SRC_Y1:   return XW'(y1_r);
      SRC_Y2:   return XW'(y2_r);
      SRC_YO:   return XW'(yo_r);
      SRC_OMY1: return ONE - XW'(y1_r);
      SRC_OMY2: return ONE - XW'(y2_r);
      SRC_OMYO: return ONE - XW'(yo_r);
      SRC_ERR:  return err;
      SRC_M:    return m_r;
      SRC_LR:   return XW'(learning_rate);
      SRC_T1:   return t1_r;
      SRC_T2:   return t2_r;
      SRC_LA:   return la_r;
      SRC_LB:   return lb_r;
      SRC_DOUT: return dout_r;
      SRC_D1:   return d1_r;
      SRC_D2:   return d2_r;
      SRC_WO1:  return XW'(w_r[WI_H1O]);
      SRC_WO2:  return XW'(w_r[WI_H2O]);
      default:  return '0;
    endcase
  endfunction

  always_comb begin
    opa = pick(cmd.mul_a);
    opb = pick(cmd.mul_b);
  end

  // product register, then round to nearest with ties upward
  assign p_rnd = p_r + HALF;

  always_ff @(posedge clk) begin
    if (cmd.mul_en) p_r <= PW'(opa) * PW'(opb);
    m_r <= p_rnd[FRAC+XW-1:FRAC];
  end

  always_comb begin
    acc_nxt = acc_r;
    case (cmd.acc_op)
      ACC_H1: acc_nxt = XW'(w_r[WI_BH1]) + (a_r ? XW'(w_r[WI_X1H1]) : '0)
                        + (b_r ? XW'(w_r[WI_X2H1]) : '0);
      ACC_H2: acc_nxt = XW'(w_r[WI_BH2]) + (a_r ? XW'(w_r[WI_X1H2]) : '0)
                        + (b_r ? XW'(w_r[WI_X2H2]) : '0);
      ACC_B2M:  acc_nxt = XW'(w_r[WI_BO]) + m_r;
      ACC_ADDM: acc_nxt = acc_r + m_r;
      default:  acc_nxt = acc_r;
    endcase
  end

  // table index: clamp below -8 and at or above 8, else scale the offset into bins
  assign off    = (FRAC+4)'(acc_r + EIGHT);
  assign scaled = SW'(off) * SW'(SIG_DEPTH);
  always_comb begin
    if (acc_r < -EIGHT)      sig_addr = '0;
    else if (acc_r >= EIGHT) sig_addr = SIG_AW'(SIG_DEPTH - 1);
    else                     sig_addr = scaled[FRAC+4+SIG_AW-1:FRAC+4];
  end

  mbp_sig_rom u_rom (
    .clk  (clk),
    .addr (sig_addr),
    .q    (sig_q)
  );

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    if (cmd.load) begin
      a_r    <= in_tdata[0];
      b_r    <= in_tdata[1];
      tgt_r  <= in_tdata[2];
      idx_r  <= in_tdata[6:3];
      last_r <= in_tlast;
    end
    case (cmd.sig_wb)
      SIG_Y1:  y1_r <= sig_q;
      SIG_Y2:  y2_r <= sig_q;
      SIG_YO:  yo_r <= sig_q;
      default: ;
    endcase
    if (cmd.save_pred) pred_r <= yo_r;
    case (cmd.m_wb)
      TMP_T1:   t1_r   <= m_r;
      TMP_T2:   t2_r   <= m_r;
      TMP_LA:   la_r   <= m_r;
      TMP_LB:   lb_r   <= m_r;
      TMP_DOUT: dout_r <= m_r;
      TMP_D1:   d1_r   <= m_r;
      TMP_D2:   d2_r   <= m_r;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_W; i++) w_r[i] <= W_RESET[i];
    end else begin
      case (cmd.upd)
        UPD_WO1: w_r[WI_H1O] <= sat_add(w_r[WI_H1O], m_r);
        UPD_WO2: w_r[WI_H2O] <= sat_add(w_r[WI_H2O], m_r);
        UPD_B2:  w_r[WI_BO]  <= sat_add(w_r[WI_BO], m_r);
        UPD_H1: begin
          if (a_r) w_r[WI_X1H1] <= sat_add(w_r[WI_X1H1], m_r);
          if (b_r) w_r[WI_X2H1] <= sat_add(w_r[WI_X2H1], m_r);
          w_r[WI_BH1] <= sat_add(w_r[WI_BH1], m_r);
        end
        UPD_H2: begin
          if (a_r) w_r[WI_X1H2] <= sat_add(w_r[WI_X1H2], m_r);
          if (b_r) w_r[WI_X2H2] <= sat_add(w_r[WI_X2H2], m_r);
          w_r[WI_BH2] <= sat_add(w_r[WI_BH2], m_r);
        end
        default: ;
      endcase
    end
  end

  // squared error after the update, added into the saturating epoch sum
  assign e2      = m_r[XW-1] ? '0 : m_r[YW-1:0];
  assign sum_w   = (EW+1)'(epoch_r) + (EW+1)'(e2);
  assign sum_sat = sum_w[EW] ? EPOCH_MAX : sum_w[EW-1:0];
  assign rd_w    = (idx_r < WIW'(NUM_W)) ? w_r[idx_r] : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      epoch_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.out_train || cmd.out_read) out_valid_r <= 1'b1;
      else if (out_tready)               out_valid_r <= 1'b0;
      if (cmd.out_train) epoch_r <= last_r ? '0 : sum_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_train) begin
      out_data_r <= {1'b0, {WW{1'b0}}, last_r && (sum_sat < error_threshold),
                     sum_sat, e2, pred_r};
    end else if (cmd.out_read) begin
      out_data_r <= {1'b0, rd_w, 1'b0, epoch_r, {YW{1'b0}}, {YW{1'b0}}};
    end
  end

  assign stat.out_free = !out_valid_r || out_tready;
  assign out_tvalid    = out_valid_r;
  assign out_tdata     = out_data_r;

  a_write_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_train || cmd.out_read) |-> (!out_valid_r || out_tready))
    else $error("result written over an untaken transaction");

  a_epoch_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_train && last_r) |=> (epoch_r == '0))
    else $error("epoch sum not cleared at end of epoch");

  a_conv_below: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(cmd.out_train) && out_tdata[54]) |-> (out_tdata[53:34] < error_threshold))
    else $error("convergence flagged above threshold");

endmodule

[design/mlp_2_2_1_backprop_trainer.sv]
// Top level of the 2-2-1 sigmoid network trainer: APB registers and the
// controller/datapath pair. Depends on mbp_pkg, mbp_ctrl and mbp_datapath.
//
// Usage:
//   The input stream carries one transaction per item. tuser selects train
//   (0) or read (1); tlast marks the last train item of an epoch. A train
//   item runs a forward pass, updates all weights and biases, runs a second
//   pass and adds the new squared error to the epoch sum. A read item
//   returns one stored weight. Every item yields exactly one result.
//   The block takes no new item until the result of the last one is
//   registered and the controller is back in idle. The length of a train
//   item is set by the one shared multiplier, with a product register and a
//   rounding register between issue and rounded product, and by the
//   registered sigmoid table, through which the dependent products of each
//   pass are sequenced.
//   Reset loads the initial weights, clears the epoch sum and restores the
//   learning rate and error threshold registers; no clearing pass is needed.
//   When the receiver stalls, the finished result holds in the output
//   register; the next item is accepted and runs, and waits at its final
//   step until the output register is free.
module mlp_2_2_1_backprop_trainer (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [7:0]                 in_tdata,   // input_a, input_b, target, weight_index[3:0], pad
  input  logic                       in_tlast,   // epoch_last
  input  logic                       in_tuser,   // cmd
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // prediction[16:0], error_squared[33:17], epoch_error[53:34], converged[54],
  // weight_value[78:55], pad
  output logic [79:0]                out_tdata,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [mbp_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]                cfg_pwdata,
  output logic [31:0]                cfg_prdata,
  output logic                       cfg_pready
);
  import mbp_pkg::*;

  logic [LRW-1:0] lr_r;
  logic [EW-1:0]  thr_r;
  logic           wr_en;
  cmd_t           cmd;
  stat_t          stat;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lr_r  <= LR_RESET;
      thr_r <= THR_RESET;
    end else if (wr_en) begin
      if (cfg_paddr[2] == REG_LR) lr_r  <= cfg_pwdata[LRW-1:0];
      else                        thr_r <= cfg_pwdata[EW-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_THR) ? 32'(thr_r) : 32'(lr_r);

  mbp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .stat      (stat),
    .in_tready (in_tready),
    .cmd       (cmd)
  );

  mbp_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_tdata        (in_tdata),
    .in_tlast        (in_tlast),
    .learning_rate   (lr_r),
    .error_threshold (thr_r),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata)
  );

endmodule

[dv/tb_mlp_2_2_1_backprop_trainer.sv]
// Testbench for the 2-2-1 backprop trainer: drives train and read items over the input
// stream, predicts every result with its own fixed-point network copy and checks it.
// Depends on mbp_pkg and mlp_2_2_1_backprop_trainer.
`timescale 1ns / 1ps

class trainer_scoreboard;
  logic [31:0] sig_lut [1024];
  logic signed [63:0] wts [9];
  logic [19:0] esum_acc;
  logic [17:0] lrate;
  logic [19:0] thresh;
  logic [79:0] pending [$];
  int errors;

  function void clear_state();
    for (int i = 0; i < 9; i++) wts[i] = mbp_pkg::W_RESET[i];
    esum_acc = '0;
    lrate = mbp_pkg::LR_RESET;
    thresh = mbp_pkg::THR_RESET;
    errors = 0;
    build_lut();
  endfunction

  function longint fxmul(longint a, longint b);
    longint p;
    p = a * b + 32768;
    if (p >= 0) return p >>> 16;
    return -(((-p) + 65535) >>> 16);
  endfunction

  function longint sat(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  function longint unsigned exp_neg(longint unsigned x);
    longint unsigned n, g, sum, term;
    n = x >> 30;
    g = (64'd1 << 30) - (x & ((64'd1 << 30) - 1));
    sum = 64'd1 << 30;
    term = sum;
    for (int k = 1; k <= 14; k++) begin
      term = ((term * g) >> 30) / k;
      sum += term;
    end
    for (longint unsigned i = 0; i <= n; i++) sum = (sum * 64'd395007542) >> 30;
    return sum;
  endfunction

  function void build_lut();
    longint unsigned off, mag, den, s;
    bit neg;
    for (int i = 0; i < 1024; i++) begin
      off = ((64'(2 * i + 1)) << 33) / 1024;
      neg = off < (64'd1 << 33);
      mag = neg ? (64'd1 << 33) - off : off - (64'd1 << 33);
      den = (64'd1 << 30) + exp_neg(mag);
      s = ((64'd1 << 46) + den / 2) / den;
      sig_lut[i] = neg ? 32'(65536 - s) : 32'(s);
    end
  endfunction

  function longint sigm(longint x);
    if (x < -524288) return sig_lut[0];
    if (x >= 524288) return sig_lut[1023];
    return sig_lut[((x + 524288) * 1024) >>> 20];
  endfunction

  function void fwd(bit a, bit b, output longint y1, output longint y2, output longint yo);
    longint s1, s2;
    s1 = wts[6];
    s2 = wts[7];
    if (a) begin s1 += wts[0]; s2 += wts[2]; end
    if (b) begin s1 += wts[1]; s2 += wts[3]; end
    y1 = sigm(s1);
    y2 = sigm(s2);
    yo = sigm(fxmul(y1, wts[4]) + fxmul(y2, wts[5]) + wts[8]);
  endfunction

  function void note_item(bit cmd, bit a, bit b, bit tgt, bit last, logic [3:0] idx);
    longint t, y1, y2, yo, dout, d1, d2, wo1, wo2, lr, e2, acc;
    logic [79:0] r;
    r = '0;
    if (cmd == mbp_pkg::CMD_READ) begin
      r[53:34] = esum_acc;
      if (idx < 9) r[78:55] = wts[idx][23:0];
    end else begin
      t = tgt ? 65536 : 0;
      lr = lrate;
      fwd(a, b, y1, y2, yo);
      r[16:0] = yo[16:0];
      wo1 = wts[4];
      wo2 = wts[5];
      dout = fxmul(fxmul(yo, 65536 - yo), t - yo);
      wts[4] = sat(wo1 + fxmul(fxmul(lr, y1), dout));
      wts[5] = sat(wo2 + fxmul(fxmul(lr, y2), dout));
      wts[8] = sat(wts[8] + fxmul(lr, dout));
      d1 = fxmul(fxmul(fxmul(y1, 65536 - y1), dout), wo1);
      d2 = fxmul(fxmul(fxmul(y2, 65536 - y2), dout), wo2);
      if (a) begin
        wts[0] = sat(wts[0] + fxmul(lr, d1));
        wts[2] = sat(wts[2] + fxmul(lr, d2));
      end
      if (b) begin
        wts[1] = sat(wts[1] + fxmul(lr, d1));
        wts[3] = sat(wts[3] + fxmul(lr, d2));
      end
      wts[6] = sat(wts[6] + fxmul(lr, d1));
      wts[7] = sat(wts[7] + fxmul(lr, d2));
      fwd(a, b, y1, y2, yo);
      e2 = fxmul(t - yo, t - yo);
      if (e2 < 0) e2 = 0;
      r[33:17] = e2[16:0];
      acc = esum_acc + e2;
      if (acc > 1048575) acc = 1048575;
      r[53:34] = acc[19:0];
      if (last) begin
        r[54] = acc < thresh;
        esum_acc = '0;
      end else esum_acc = acc[19:0];
    end
    pending.push_back(r);
  endfunction

  function void check_result(logic [79:0] got);
    logic [79:0] exp_r;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result exp none got %h", $time, got);
      errors++;
      return;
    end
    exp_r = pending.pop_front();
    if (got[16:0] !== exp_r[16:0])
      $display("%0t: prediction exp %0d got %0d", $time, exp_r[16:0], got[16:0]);
    if (got[33:17] !== exp_r[33:17])
      $display("%0t: error_squared exp %0d got %0d", $time, exp_r[33:17], got[33:17]);
    if (got[53:34] !== exp_r[53:34])
      $display("%0t: epoch_error exp %0d got %0d", $time, exp_r[53:34], got[53:34]);
    if (got[54] !== exp_r[54])
      $display("%0t: converged exp %0d got %0d", $time, exp_r[54], got[54]);
    if (got[78:55] !== exp_r[78:55])
      $display("%0t: weight_value exp %h got %h", $time, exp_r[78:55], got[78:55]);
    if (got[78:0] !== exp_r[78:0]) errors++;
  endfunction
endclass

module tb_mlp_2_2_1_backprop_trainer;
  import mbp_pkg::*;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0, in_tlast = 0, in_tuser = 0;
  logic [7:0] in_tdata = '0;
  logic in_tready;
  logic out_tvalid;
  logic out_tready = 0;
  logic [79:0] out_tdata;
  logic cfg_psel = 0, cfg_penable = 0, cfg_pwrite = 0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;
  trainer_scoreboard sb;

  mlp_2_2_1_backprop_trainer dut (.*);

  always #1 clk = ~clk;

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

  // hold valid across a zero gap so it is assigned only once per edge
  task automatic send_item(bit cmd, bit a, bit b, bit tgt, bit last, logic [3:0] idx);
    int idle;
    idle = $urandom_range(0, 7);
    if (idle > 0) begin
      in_tvalid <= 0;
      repeat (idle) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= cmd;
    in_tlast <= last;
    in_tdata <= {1'b0, idx, tgt, b, a};
    do @(posedge clk); while (!in_tready);
    sb.note_item(cmd, a, b, tgt, last, idx);
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_AW-1:0] addr, logic [31:0] val);
    cfg_psel <= 1;
    cfg_pwrite <= 1;
    cfg_paddr <= addr;
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 0;
    cfg_penable <= 0;
    cfg_pwrite <= 0;
    @(posedge clk);
    if (addr == 3'd0) sb.lrate = val[17:0];
    else if (addr == 3'd4) sb.thresh = val[19:0];
  endtask

  task automatic train_phase(int n);
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 9);
      if (k == 0)
        send_item(CMD_READ, 1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                  4'($urandom));
      else if (k == 1)
        send_item(CMD_READ, 1'b0, 1'b0, 1'b0, 1'b0, 4'($urandom_range(0, 8)));
      else
        send_item(CMD_TRAIN, 1'($urandom), 1'($urandom), 1'($urandom), (i % 4) == 3, 4'd0);
    end
  endtask

  // receiver: random stalls, occasional long open stretches
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  initial begin
    int stall;
    forever begin
      @(posedge clk);
      if (stall > 0) begin
        out_tready <= 0;
        stall--;
      end else begin
        out_tready <= 1;
        if (out_tvalid && out_tready && $urandom_range(0, 3) != 0) stall = $urandom_range(0, 7);
      end
    end
  end

  initial begin
    sb = new();
    sb.clear_state();
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed: every weight, XOR corners, epoch ends, bad indices
    for (int i = 0; i < 9; i++) send_item(CMD_READ, 1'b0, 1'b0, 1'b0, 1'b0, 4'(i));
    send_item(CMD_READ, 1'b1, 1'b1, 1'b1, 1'b1, 4'd15);
    send_item(CMD_READ, 1'b0, 1'b0, 1'b0, 1'b0, 4'd9);
    for (int i = 0; i < 4; i++) send_item(CMD_TRAIN, i[0], i[1], i[0] ^ i[1], i == 3, 4'd15);
    send_item(CMD_TRAIN, 1'b1, 1'b1, 1'b1, 1'b1, 4'd0);
    send_item(CMD_READ, 1'b0, 1'b0, 1'b0, 1'b0, 4'd8);
    drain();
    write_reg(3'd4, 32'hFFFFF);
    write_reg(3'd0, 32'd0);
    train_phase(60);
    drain();
    write_reg(3'd0, 32'h3FFFF);
    write_reg(3'd4, 32'd0);
    train_phase(150);
    drain();
    write_reg(3'd0, 32'd41812);
    write_reg(3'd4, 32'd6000);
    train_phase(250);
    drain();
    write_reg(3'd0, $urandom_range(0, 262143));
    write_reg(3'd4, $urandom_range(0, 1048575));
    train_phase(270);
    drain();
    if (sb.errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule

[mlp_2_2_1_backprop_trainer.f]
design/mbp_pkg.sv
design/mbp_sig_rom.sv
design/mbp_ctrl.sv
design/mbp_datapath.sv
design/mlp_2_2_1_backprop_trainer.sv
dv/tb_mlp_2_2_1_backprop_trainer.sv
